[src/trfp_pkg.sv]
package trfp_pkg;

	// Buffer sizes and the record count ceiling.
	localparam int KEY_MAX     = 16;
	localparam int VALUE_MAX   = 32;
	localparam int MAX_RECORDS = 32;

	// Derived widths.
	localparam int IDX_W    = $clog2(((KEY_MAX > VALUE_MAX) ? KEY_MAX : VALUE_MAX) + 1);
	localparam int KLEN_W   = $clog2(KEY_MAX + 1);
	localparam int RAM_DEPTH = KEY_MAX + VALUE_MAX;
	localparam int TOT_W    = $clog2(RAM_DEPTH);
	localparam int CNT_W    = 6;
	localparam int TAG_LEN  = 8;

	// Characters with a meaning to the parser.
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Result kinds.
	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       char_byte;
		logic             last;
		logic             sum_ok;
		logic [7:0]       sum_value;
		logic [CNT_W-1:0] record_count;
	} res_t;

	// Key text of the record that announces the checksum byte.
	function automatic logic [7:0] tag_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = 8'h43; // C
			3'd1: ch = 8'h48; // H
			3'd2: ch = 8'h45; // E
			3'd3: ch = 8'h43; // C
			3'd4: ch = 8'h4B; // K
			3'd5: ch = 8'h53; // S
			3'd6: ch = 8'h55; // U
			3'd7: ch = 8'h4D; // M
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
	endfunction

endpackage

[src/text_record_frame_parser.sv]
// Line-oriented key/value frame parser. Each slave-side transaction carries one
// received byte. A newline opens a record made of an upper-cased key, a tab and
// a value that the next newline closes; the key and value characters are held
// in one shared buffer memory (keys in the low entries, values above them).
// When a record closes, its key characters and then its value characters stream
// out on the master side (tuser says which), the final one flagged by tlast. A
// record whose value fills the value buffer is dropped; keys longer than the key
// buffer are cut short. The record keyed CHECKSUM is followed by one byte that
// ends the frame: a single frame-end transaction reports the modulo-256 byte
// sum, whether it is zero, and the number of records delivered (saturating).
// Colon-started hex records are skipped and clear the sum. Timing: an ordinary
// byte does not hold off the next. A byte that closes a record holds off the next
// byte until its characters are read from the buffer and out of the read stage,
// with results leaving at one per cycle while the master side keeps tready high;
// a stall there stalls the buffer reads. The buffer needs no clearing after reset.
module text_record_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] char_byte, [8] sum_ok, [16:9] sum_value,
	                               // [22:17] record_count, [23] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last
);

	import trfp_pkg::*;

	// Parser modes.
	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_BEGIN = 3'd1;
	localparam logic [2:0] M_KEY   = 3'd2;
	localparam logic [2:0] M_VALUE = 3'd3;
	localparam logic [2:0] M_CSUM  = 3'd4;
	localparam logic [2:0] M_HEX   = 3'd5;

	// Parser state.
	logic [2:0]        mode_q, mode_d;
	logic [7:0]        sum_q, sum_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [KLEN_W-1:0] klen_q, klen_d;
	logic [CNT_W-1:0]  recs_q, recs_d;
	logic              tag_ok_q, tag_ok_d;

	// Record streaming state.
	logic              stream_q;
	logic [TOT_W-1:0]  rd_idx_q;
	logic [TOT_W-1:0]  last_idx_q, last_idx_d;
	logic              start;

	// Read pipeline and output buffering.
	logic              pend_s1;
	logic [1:0]        kind_s1;
	logic              last_s1;
	logic [7:0]        rdata;
	res_t              m_q, sk_q, land;
	logic              m_valid_q, sk_valid_q, land_v;

	// Frame end result built on the accepted checksum byte.
	logic              fe_valid;
	logic [7:0]        fe_sum;

	// Buffer write port.
	logic              wr_en;
	logic [TOT_W-1:0]  wr_addr;
	logic [7:0]        wr_data;

	logic              accept, pop, rd_go;
	logic [7:0]        raw, up, sum_add;
	logic [1:0]        occ;
	logic [TOT_W-1:0]  rd_addr;

	assign raw     = s_tdata;
	assign up      = to_upper(raw);
	assign sum_add = sum_q + raw;

	// Input is held off while a record streams or its characters are still in flight.
	assign s_tready = !stream_q && !pend_s1 && !sk_valid_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		mode_d     = mode_q;
		sum_d      = sum_q;
		idx_d      = idx_q;
		klen_d     = klen_q;
		recs_d     = recs_q;
		tag_ok_d   = tag_ok_q;
		last_idx_d = last_idx_q;
		start      = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = TOT_W'(idx_q);
		wr_data    = up;
		fe_valid   = 1'b0;
		fe_sum     = sum_add;
		if (accept) begin
			if (raw == CH_COLON && mode_q != M_CSUM) begin
				// A colon starts a hex record and drops any partial record.
				mode_d = M_HEX;
			end else begin
				case (mode_q)
					M_IDLE: begin
						sum_d = sum_add;
						if (up == CH_LF) begin
							mode_d = M_BEGIN;
						end
					end
					M_BEGIN: begin
						// The first byte of a record, unless it is a colon, is always a key character.
						sum_d    = sum_add;
						wr_en    = 1'b1;
						wr_addr  = '0;
						idx_d    = IDX_W'(1);
						tag_ok_d = (up == tag_char(3'd0));
						mode_d   = M_KEY;
					end
					M_KEY: begin
						sum_d = sum_add;
						if (up == CH_TAB) begin
							klen_d = KLEN_W'(idx_q);
							if (idx_q == IDX_W'(TAG_LEN) && tag_ok_q) begin
								mode_d = M_CSUM;
							end else begin
								idx_d  = '0;
								mode_d = M_VALUE;
							end
						end else if (idx_q < IDX_W'(KEY_MAX)) begin
							wr_en = 1'b1;
							idx_d = idx_q + IDX_W'(1);
							if (idx_q < IDX_W'(TAG_LEN)) begin
								tag_ok_d = tag_ok_q && (up == tag_char(idx_q[2:0]));
							end
						end
					end
					M_VALUE: begin
						sum_d = sum_add;
						if (up == CH_LF) begin
							if (idx_q < IDX_W'(VALUE_MAX)) begin
								start      = 1'b1;
								last_idx_d = TOT_W'(klen_q) + TOT_W'(idx_q) - TOT_W'(1);
								if (recs_q < CNT_W'(MAX_RECORDS)) begin
									recs_d = recs_q + CNT_W'(1);
								end
							end
							idx_d  = '0;
							mode_d = M_BEGIN;
						end else if (up != CH_CR && idx_q < IDX_W'(VALUE_MAX)) begin
							wr_en   = 1'b1;
							wr_addr = TOT_W'(idx_q) + TOT_W'(KEY_MAX);
							idx_d   = idx_q + IDX_W'(1);
						end
					end
					M_CSUM: begin
						// Checksum byte: report the frame and clear the sum, index, key length and record count.
						fe_valid = 1'b1;
						mode_d   = M_IDLE;
						sum_d    = '0;
						idx_d    = '0;
						klen_d   = '0;
						recs_d   = '0;
					end
					M_HEX: begin
						if (!is_hex(up)) begin
							sum_d  = '0;
							mode_d = M_IDLE;
						end
					end
					default: begin
						sum_d  = sum_add;
						mode_d = M_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			sum_q    <= '0;
			idx_q    <= '0;
			klen_q   <= '0;
			recs_q   <= '0;
			tag_ok_q <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			sum_q    <= sum_d;
			idx_q    <= idx_d;
			klen_q   <= klen_d;
			recs_q   <= recs_d;
			tag_ok_q <= tag_ok_d;
		end
	end

	// A buffer read is issued only when the output register and the skid stage
	// can absorb every character already read, so none is ever lost.
	assign pop   = m_valid_q && m_tready;
	assign occ   = {1'b0, m_valid_q} + {1'b0, sk_valid_q} + {1'b0, pend_s1};
	assign rd_go = stream_q && ((occ - {1'b0, pop}) <= 2'd1);

	always_comb begin
		if (rd_idx_q < TOT_W'(klen_q)) begin
			rd_addr = rd_idx_q;
		end else begin
			rd_addr = rd_idx_q - TOT_W'(klen_q) + TOT_W'(KEY_MAX);
		end
	end

	trfp_ram #(
		.DEPTH(RAM_DEPTH),
		.WIDTH(8)
	) u_buf (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_go),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_q <= 1'b0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= rd_go;
			if (start) begin
				stream_q <= 1'b1;
			end else if (rd_go && rd_idx_q == last_idx_q) begin
				stream_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_idx_q <= last_idx_d;
		if (start) begin
			rd_idx_q <= '0;
		end else if (rd_go) begin
			rd_idx_q <= rd_idx_q + TOT_W'(1);
		end
		if (rd_go) begin
			kind_s1 <= (rd_idx_q < TOT_W'(klen_q)) ? KIND_KEY : KIND_VALUE;
			last_s1 <= (rd_idx_q == last_idx_q);
		end
	end

	// The item arriving at the output side: a buffer character or a frame end.
	always_comb begin
		land_v = pend_s1 || fe_valid;
		if (pend_s1) begin
			land.kind         = kind_s1;
			land.char_byte    = rdata;
			land.last         = last_s1;
			land.sum_ok       = 1'b0;
			land.sum_value    = '0;
			land.record_count = '0;
		end else begin
			land.kind         = KIND_END;
			land.char_byte    = '0;
			land.last         = 1'b1;
			land.sum_ok       = (fe_sum == 8'd0);
			land.sum_value    = fe_sum;
			land.record_count = recs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else begin
			if (!m_valid_q || pop) begin
				if (sk_valid_q) begin
					m_valid_q  <= 1'b1;
					sk_valid_q <= land_v;
				end else begin
					m_valid_q  <= land_v;
					sk_valid_q <= 1'b0;
				end
			end else if (land_v) begin
				sk_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!m_valid_q || pop) begin
			if (sk_valid_q) begin
				m_q  <= sk_q;
				sk_q <= land;
			end else begin
				m_q <= land;
			end
		end else if (land_v) begin
			sk_q <= land;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_q.record_count, m_q.sum_value, m_q.sum_ok, m_q.char_byte};
	assign m_tuser  = m_q.kind;
	assign m_tlast  = m_q.last;

endmodule

[src/trfp_ram.sv]
module trfp_ram #(
	parameter int DEPTH = 48,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[dv/text_record_frame_parser_checker.sv]
`timescale 1ns / 100ps

// Watches both stream channels of the record parser, predicts the result
// transactions for every accepted byte and compares them in order.
module text_record_frame_parser_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] char_byte, [8] sum_ok, [16:9] sum_value,
	                               // [22:17] record_count, [23] zero
	input  logic [1:0]  m_tuser,   // [1:0] kind
	input  logic        m_tlast,
	output int          errors,
	output int          outstanding,
	output int          results_seen,
	output int          frames_seen
);
	import trfp_pkg::*;

	typedef enum logic [2:0] {
		PM_IDLE, PM_BEGIN, PM_KEY, PM_VALUE, PM_CSUM, PM_HEX
	} parse_mode_e;

	localparam logic [63:0] CSUM_TAG = "CHECKSUM";

	parse_mode_e pmode;
	logic [7:0]  sum_acc;
	logic [5:0]  pos;
	logic [4:0]  key_len;
	logic [5:0]  rec_cnt;
	logic [7:0]  key_buf [KEY_MAX];
	logic [7:0]  val_buf [VALUE_MAX];
	res_t        record_chars_q [$];
	int          err_cnt;
	int          res_cnt;
	int          end_cnt;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic logic key_is_checksum();
		for (int i = 0; i < TAG_LEN; i++) begin
			if (key_buf[i] != CSUM_TAG[63 - 8 * i -: 8]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic clear_parse();
		pmode   = PM_IDLE;
		sum_acc = '0;
		pos     = '0;
		key_len = '0;
		rec_cnt = '0;
	endtask

	task automatic push_result(input logic [1:0] k, input logic [7:0] ch, input logic ok,
			input logic [7:0] sv, input logic [5:0] cnt);
		res_t r;
		r.kind         = k;
		r.char_byte    = ch;
		r.last         = 1'b0;
		r.sum_ok       = ok;
		r.sum_value    = sv;
		r.record_count = cnt;
		record_chars_q.push_back(r);
	endtask

	task automatic predict_byte(input logic [7:0] raw);
		logic [7:0] c;
		logic       colon_hit;
		int         first;
		res_t       tail;
		colon_hit = 1'b0;
		first     = record_chars_q.size();
		if (raw == CH_COLON && pmode != PM_CSUM) begin
			pmode     = PM_HEX;
			colon_hit = 1'b1;
		end
		if (pmode != PM_HEX) begin
			sum_acc = sum_acc + raw;
		end
		c = upcase(raw);
		case (pmode)
			PM_IDLE: begin
				if (c == CH_LF) begin
					pmode = PM_BEGIN;
				end
			end
			PM_BEGIN: begin
				// Whatever follows the newline, unless it is a colon, is taken as the first key character.
				key_buf[0] = c;
				pos        = 6'd1;
				pmode      = PM_KEY;
			end
			PM_KEY: begin
				if (c == CH_TAB) begin
					key_len = pos[4:0];
					if (pos == TAG_LEN && key_is_checksum()) begin
						pmode = PM_CSUM;
					end else begin
						pos   = '0;
						pmode = PM_VALUE;
					end
				end else if (pos < KEY_MAX) begin
					key_buf[pos[3:0]] = c;
					pos++;
				end
			end
			PM_VALUE: begin
				if (c == CH_LF) begin
					// A value that filled its buffer loses the whole record.
					if (pos < VALUE_MAX) begin
						for (int i = 0; i < key_len && i < KEY_MAX; i++) begin
							push_result(KIND_KEY, key_buf[i], 1'b0, 8'h00, 6'd0);
						end
						for (int i = 0; i < pos; i++) begin
							push_result(KIND_VALUE, val_buf[i], 1'b0, 8'h00, 6'd0);
						end
						if (rec_cnt < MAX_RECORDS) begin
							rec_cnt++;
						end
					end
					pos   = '0;
					pmode = PM_BEGIN;
				end else if (c != CH_CR && pos < VALUE_MAX) begin
					val_buf[pos[4:0]] = c;
					pos++;
				end
			end
			PM_CSUM: begin
				push_result(KIND_END, 8'h00, sum_acc == 8'h00, sum_acc, rec_cnt);
				clear_parse();
			end
			PM_HEX: begin
				if (!colon_hit && !((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46))) begin
					sum_acc = '0;
					pmode   = PM_IDLE;
				end
			end
			default: pmode = PM_IDLE;
		endcase
		if (record_chars_q.size() > first) begin
			tail      = record_chars_q.pop_back();
			tail.last = 1'b1;
			record_chars_q.push_back(tail);
		end
	endtask

	task automatic note_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		if (err_cnt < 10) begin
			$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
		end
		err_cnt++;
	endtask

	task automatic check_result();
		res_t e;
		if (record_chars_q.size() == 0) begin
			note_mismatch("unexpected result transaction", 0, m_tdata);
		end else begin
			e = record_chars_q.pop_front();
			if (m_tuser != e.kind) note_mismatch("kind", e.kind, m_tuser);
			if (m_tdata[7:0] != e.char_byte) note_mismatch("char_byte", e.char_byte, m_tdata[7:0]);
			if (m_tlast != e.last) note_mismatch("last", e.last, m_tlast);
			if (m_tdata[8] != e.sum_ok) note_mismatch("sum_ok", e.sum_ok, m_tdata[8]);
			if (m_tdata[16:9] != e.sum_value) note_mismatch("sum_value", e.sum_value, m_tdata[16:9]);
			if (m_tdata[22:17] != e.record_count) begin
				note_mismatch("record_count", e.record_count, m_tdata[22:17]);
			end
			if (m_tdata[23] != 1'b0) note_mismatch("tdata padding", 0, m_tdata[23]);
			if (e.kind == KIND_END) end_cnt++;
		end
		res_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			record_chars_q.delete();
			err_cnt      = 0;
			res_cnt      = 0;
			end_cnt      = 0;
			errors       <= 0;
			outstanding  <= 0;
			results_seen <= 0;
			frames_seen  <= 0;
		end else begin
			// Predict first: a result can never leave before the byte that causes it.
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				check_result();
			end
			errors       <= err_cnt;
			outstanding  <= record_chars_q.size();
			results_seen <= res_cnt;
			frames_seen  <= end_cnt;
		end
	end

endmodule

[dv/text_record_frame_parser_tb.sv]
`timescale 1ns / 100ps

// Top of the record parser bench. It only makes stimulus and gives the verdict;
// the checker beside the block does all prediction and comparison.
module text_record_frame_parser_tb;
	import trfp_pkg::*;

	// Cycles with no transaction on either channel before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	// Length of the long receiver hold-off that backs the block up.
	localparam int SQUEEZE_CYCLES = 400;
	// Least number of input bytes to send in all, opening bytes included.
	localparam int TARGET_ITEMS = 280;
	localparam logic [63:0] CSUM_KEY = "CHECKSUM";

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int errors;
	int outstanding;
	int results_seen;
	int frames_seen;
	int bytes_sent;
	int quiet_cycles;
	int phase;
	logic [7:0] gen_sum;

	// Opening bytes: both byte extremes in the idle state, a record whose key
	// starts with a tab and holds a carriage return and a newline, a value with
	// a skipped carriage return, a hex record entered right after a record and
	// ended by a non-hex letter, then a mixed-case CHECKSUM key whose checksum
	// byte is itself a colon.
	logic [7:0] opening_bytes [29] = '{
		8'h00, 8'hFF, CH_LF, CH_TAB, 8'h61, CH_CR, CH_LF, CH_TAB, 8'h7A, CH_CR,
		8'hFF, CH_LF, CH_COLON, 8'h61, 8'h46, CH_COLON, 8'h39, 8'h47, CH_LF,
		8'h63, 8'h68, 8'h65, 8'h63, 8'h6B, 8'h53, 8'h55, 8'h4D, CH_TAB, CH_COLON
	};

	always #10 clk = ~clk;

	text_record_frame_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	text_record_frame_parser_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.errors       (errors),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.frames_seen  (frames_seen)
	);

	// Offers one byte, possibly after some idle cycles, and returns at the edge
	// where the transaction completes. The valid stays high into the next call
	// when no idle cycle is drawn, so back-to-back transfers occur too.
	task automatic send_byte(input logic [7:0] b);
		int idle_pct;
		idle_pct = (phase == 0) ? 6 : (phase == 1) ? 46 : 0;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do begin
			@(posedge clk);
		end while (!s_tready);
		gen_sum = gen_sum + b;
		bytes_sent++;
	endtask

	// Sends one frame: optional noise, a newline, a number of records, then the
	// CHECKSUM record and its checksum byte. A crowded frame is made of many
	// one-character records so that the record count saturates.
	task automatic send_frame(input bit crowded);
		int nrec;
		int klen;
		int vlen;
		int pick;
		logic [7:0] b;
		if (!crowded && $urandom_range(99) < 30) begin
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom_range(255));
				if (b == CH_COLON) b = CH_CR;
				send_byte(b);
			end
		end
		send_byte(CH_LF);
		nrec = crowded ? MAX_RECORDS + 2 : $urandom_range(0, 5);
		for (int r = 0; r < nrec; r++) begin
			// Keys are mostly short; some run past the key buffer and get cut.
			klen = crowded ? 1 : ($urandom_range(99) < 12) ? $urandom_range(KEY_MAX + 1, KEY_MAX + 4)
				: $urandom_range(1, 10);
			for (int k = 0; k < klen; k++) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					b = 8'h41 + 8'($urandom_range(25));
				end else if (pick < 70) begin
					b = 8'h61 + 8'($urandom_range(25));
				end else if (pick < 85) begin
					b = 8'h30 + 8'($urandom_range(9));
				end else begin
					b = 8'($urandom_range(255));
					if (b == CH_TAB || b == CH_COLON) b = 8'h80;
				end
				send_byte(b);
			end
			send_byte(CH_TAB);
			// Values near the value buffer size exercise the drop rule.
			vlen = crowded ? 0 : ($urandom_range(99) < 15) ? $urandom_range(VALUE_MAX - 1, VALUE_MAX + 4)
				: $urandom_range(0, 8);
			for (int v = 0; v < vlen; v++) begin
				if ($urandom_range(99) < 10) begin
					b = CH_CR;
				end else begin
					b = 8'($urandom_range(255));
					if (b == CH_LF || b == CH_COLON) b = 8'h7F;
				end
				send_byte(b);
			end
			// Now and then a hex record cuts the current record short.
			if (!crowded && $urandom_range(99) < 10) begin
				send_byte(CH_COLON);
				repeat ($urandom_range(0, 6)) begin
					pick = $urandom_range(25);
					if (pick < 10) b = 8'h30 + 8'(pick);
					else if (pick < 16) b = 8'h61 + 8'(pick - 10);
					else if (pick < 22) b = 8'h41 + 8'(pick - 16);
					else b = CH_COLON;
					send_byte(b);
				end
				do begin
					b = 8'($urandom_range(255));
				end while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46)
					|| (b >= 8'h61 && b <= 8'h66) || b == CH_COLON);
				send_byte(b);
				gen_sum = 8'h00;
			end
			send_byte(CH_LF);
		end
		for (int k = 0; k < TAG_LEN; k++) begin
			b = CSUM_KEY[63 - 8 * k -: 8];
			if ($urandom_range(1) == 1) b = b | 8'h20;
			send_byte(b);
		end
		send_byte(CH_TAB);
		// Mostly a correct checksum byte, sometimes an arbitrary one.
		if ($urandom_range(99) < 80) send_byte(8'h00 - gen_sum);
		else send_byte(8'($urandom_range(255)));
		gen_sum = 8'h00;
	endtask

	// Receiver side. In the second phase it first holds tready low for a long,
	// counted stretch while the sender keeps offering, which backs the block up.
	initial begin
		int hold;
		bit squeezed;
		m_tready = 1'b0;
		squeezed = 1'b0;
		forever begin
			@(posedge clk);
			if (phase == 1 && !squeezed) begin
				squeezed = 1'b1;
				m_tready <= 1'b0;
				hold = 0;
				while (hold < SQUEEZE_CYCLES) begin
					@(posedge clk);
					hold++;
				end
			end else begin
				m_tready <= ($urandom_range(99) >= ((phase == 0) ? 46 : (phase == 1) ? 6 : 0));
			end
		end
	end

	// Watchdog: any cycle with a transaction on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[text_record_frame_parser] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		bit crowded_done;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		phase        = 0;
		bytes_sent   = 0;
		gen_sum      = 8'h00;
		crowded_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bytes[i]) begin
			send_byte(opening_bytes[i]);
		end
		gen_sum = 8'h00;

		// Random frames. The idling pattern changes with the byte count; the
		// crowded frame opens the phase without idling.
		while (bytes_sent < TARGET_ITEMS) begin
			if (phase == 0 && bytes_sent >= 90) begin
				phase <= 1;
			end else if (phase == 1 && bytes_sent >= 150) begin
				phase <= 2;
			end
			if (phase == 2 && !crowded_done) begin
				crowded_done = 1'b1;
				send_frame(1'b1);
			end else begin
				send_frame(1'b0);
			end
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every predicted result, then give the block time to
		// show any stray transaction.
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);

		$display("Run covered %0d input bytes in directed and random frames, %0d result", bytes_sent,
			results_seen);
		$display("transactions and %0d frame ends, with idling, back-pressure and record count saturation.",
			frames_seen);
		if (errors == 0) begin
			$display("[text_record_frame_parser] OK");
		end else begin
			$display("[text_record_frame_parser] ERROR");
		end
		$finish;
	end

endmodule
